FILE: sv/tet_pkg.sv
package tet_pkg;

	localparam int SLOT_COUNT   = 32;
	localparam int MAX_RESULTS  = 32;
	localparam int SLOT_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
	localparam int TICK_W       = 32;
	localparam int SLOT_FIELD_W = 5;

	localparam logic KIND_SCHEDULE = 1'b0;
	localparam logic KIND_POLL     = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic              poll;
		logic              fire_en;
		logic [TICK_W-1:0] tick;
	} cell_cmd_t;

endpackage

FILE: sv/tet_cell.sv
module tet_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  tet_pkg::cell_cmd_t cmd,
	input  logic               tok_in,
	output logic               tok_out,
	output logic               hit
);

	logic                       tok_q;
	logic                       active_q;
	logic [tet_pkg::TICK_W-1:0] deadline_q;
	logic                       due;

	assign due = active_q && (deadline_q <= cmd.tick) && cmd.fire_en;
	assign hit = tok_q && (cmd.poll ? due : !active_q);

	// a schedule token stops at the first free cell; a poll token runs the whole row
	assign tok_out = tok_q && (cmd.poll || active_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q    <= 1'b0;
			active_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (hit) begin
				active_q <= !cmd.poll;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit && !cmd.poll) begin
			deadline_q <= cmd.tick;
		end
	end

endmodule

FILE: sv/timed_event_slot_table_core.sv
// Table of one-shot timed events held in a row of cells, one cell per slot.
// Command channel: drive kind and tick_value with start high; the item is
// taken at the rising edge where start is high and busy is low.
// A schedule (kind 0) sends a token down the row that stops in the lowest
// free cell, which stores the deadline; one reply follows, or table_full.
// A poll (kind 1) walks the token over every cell, one cell per clock; each
// active cell whose deadline is at or below the tick fires and frees itself.
// Results appear on the result ports for one cycle with result_valid high;
// they cannot be held off. A fired slot is held until the next fire or the
// end of the scan so the final one of a run carries last_of_run; a poll
// firing nothing gives a single reply with fired low.
// Busy: a schedule stays busy until its token lands in a free cell or the
// row ends; a poll stays busy while its token walks the whole row and
// until its final reply is issued. No new command is taken while busy.
// Reset clears every slot's active bit and the sequencer; deadlines are
// written before they are ever compared.
module timed_event_slot_table_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 kind,
	input  logic [tet_pkg::TICK_W-1:0]           tick_value,
	output logic                                 result_valid,
	output logic                                 reply_kind,
	output logic [tet_pkg::SLOT_FIELD_W-1:0]     slot,
	output logic                                 table_full,
	output logic                                 fired,
	output logic [tet_pkg::TICK_W-1:0]           fire_tick,
	output logic                                 last_of_run
);

	localparam int N = tet_pkg::SLOT_COUNT;

	tet_pkg::state_t            state_q, state_d;
	logic                       kind_q;
	logic [tet_pkg::TICK_W-1:0] tick_q;
	logic [tet_pkg::SLOT_W-1:0] pos_q;
	logic [tet_pkg::CNT_W-1:0]  cnt_q;
	logic                       pend_v_q;
	logic [tet_pkg::SLOT_W-1:0] pend_slot_q;

	logic                       accept;
	logic                       scan_end;
	logic                       any_hit;
	logic [N-1:0]               hits;
	logic [N:0]                 tok;
	tet_pkg::cell_cmd_t         cmd;

	logic                       emit;
	logic                       e_kind, e_full, e_fired, e_last;
	logic [tet_pkg::SLOT_W-1:0] e_slot;
	logic                       e_tick_sel;
	logic                       pend_set, pend_clr, cnt_inc;

	logic [tet_pkg::SLOT_W+tet_pkg::SLOT_FIELD_W-1:0] slot_ext;

	logic                                 valid_q;
	logic                                 rkind_q, full_q, fired_q, last_q;
	logic [tet_pkg::SLOT_FIELD_W-1:0]     slot_q;
	logic [tet_pkg::TICK_W-1:0]           ftick_q;

	assign busy     = (state_q != tet_pkg::ST_IDLE);
	assign accept   = start && !busy;
	assign scan_end = (pos_q == tet_pkg::SLOT_W'(N - 1));
	assign any_hit  = |hits;

	assign cmd.poll    = (kind_q == tet_pkg::KIND_POLL);
	assign cmd.fire_en = (cnt_q != tet_pkg::CNT_W'(tet_pkg::MAX_RESULTS));
	assign cmd.tick    = tick_q;

	assign tok[0] = accept;

	for (genvar i = 0; i < N; i++) begin : g_cell
		tet_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.hit     (hits[i])
		);
	end

	always_comb begin
		state_d    = state_q;
		emit       = 1'b0;
		e_kind     = tet_pkg::KIND_SCHEDULE;
		e_slot     = '0;
		e_full     = 1'b0;
		e_fired    = 1'b0;
		e_last     = 1'b0;
		e_tick_sel = 1'b0;
		pend_set   = 1'b0;
		pend_clr   = 1'b0;
		cnt_inc    = 1'b0;
		unique case (state_q)
			tet_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = tet_pkg::ST_SCAN;
				end
			end
			tet_pkg::ST_SCAN: begin
				if (!cmd.poll) begin
					if (any_hit) begin
						emit    = 1'b1;
						e_slot  = pos_q;
						e_last  = 1'b1;
						state_d = tet_pkg::ST_IDLE;
					end else if (scan_end) begin
						emit    = 1'b1;
						e_full  = 1'b1;
						e_last  = 1'b1;
						state_d = tet_pkg::ST_IDLE;
					end
				end else begin
					if (any_hit) begin
						// release the previous fire, park this one
						emit       = pend_v_q;
						e_kind     = tet_pkg::KIND_POLL;
						e_slot     = pend_slot_q;
						e_fired    = 1'b1;
						e_tick_sel = 1'b1;
						pend_set   = 1'b1;
						cnt_inc    = 1'b1;
					end
					if (scan_end) begin
						state_d = tet_pkg::ST_FIN;
					end
				end
			end
			tet_pkg::ST_FIN: begin
				emit       = 1'b1;
				e_kind     = tet_pkg::KIND_POLL;
				e_slot     = pend_v_q ? pend_slot_q : '0;
				e_fired    = pend_v_q;
				e_tick_sel = pend_v_q;
				e_last     = 1'b1;
				pend_clr   = 1'b1;
				state_d    = tet_pkg::ST_IDLE;
			end
			default: begin
				state_d = tet_pkg::ST_IDLE;
			end
		endcase
	end

	assign slot_ext = {{tet_pkg::SLOT_FIELD_W{1'b0}}, e_slot};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tet_pkg::ST_IDLE;
			pend_v_q <= 1'b0;
			cnt_q    <= '0;
			pos_q    <= '0;
			valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= emit;
			if (accept) begin
				pend_v_q <= 1'b0;
				cnt_q    <= '0;
				pos_q    <= '0;
			end else begin
				if (state_q == tet_pkg::ST_SCAN) begin
					pos_q <= pos_q + tet_pkg::SLOT_W'(1);
				end
				if (pend_set) begin
					pend_v_q <= 1'b1;
				end else if (pend_clr) begin
					pend_v_q <= 1'b0;
				end
				if (cnt_inc) begin
					cnt_q <= cnt_q + tet_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			tick_q <= tick_value;
		end
		if (pend_set) begin
			pend_slot_q <= pos_q;
		end
		if (emit) begin
			rkind_q <= e_kind;
			slot_q  <= slot_ext[tet_pkg::SLOT_FIELD_W-1:0];
			full_q  <= e_full;
			fired_q <= e_fired;
			ftick_q <= e_tick_sel ? tick_q : '0;
			last_q  <= e_last;
		end
	end

	assign result_valid = valid_q;
	assign reply_kind   = rkind_q;
	assign slot         = slot_q;
	assign table_full   = full_q;
	assign fired        = fired_q;
	assign fire_tick    = ftick_q;
	assign last_of_run  = last_q;

endmodule
